/* hw/rtl/rafc_pkg.sv */
// Shared types, constants and helper functions for the ASCII tag frame checker.
`timescale 1ns / 1ps
`default_nettype none

package rafc_pkg;

   localparam logic [7:0] START_BYTE = 8'h02;
   localparam logic [7:0] END_BYTE   = 8'h03;
   localparam int unsigned TAG_BITS  = 40;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag_id;
      logic [7:0]          computed_checksum;
      logic [7:0]          received_checksum;
      logic                checksum_ok;
      logic                frame_captured;
   } result_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      logic [3:0] n;
      d = 8'h00;
      n = 4'h0;
      if (c inside {["0":"9"]}) begin
         d = c - 8'h30;
         n = d[3:0];
      end else if (c inside {["A":"F"]}) begin
         d = c - 8'h37;
         n = d[3:0];
      end
      return n;
   endfunction

   function automatic logic [7:0] xor_bytes(input logic [TAG_BITS-1:0] v);
      return v[39:32] ^ v[31:24] ^ v[23:16] ^ v[15:8] ^ v[7:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rafc_parser.sv */
// Frame parser state and result computation for one received byte.
`timescale 1ns / 1ps
`default_nettype none

module rafc_parser #(
   parameter int unsigned TAG_CHARS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           rx_byte,
   output logic                      emit,
   output rafc_pkg::result_type      result
);

   localparam int unsigned CNT_W = $clog2(TAG_CHARS + 2);

   logic                          capture_ff, capture_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [rafc_pkg::TAG_BITS-1:0] tag_ff, tag_in;
   logic [7:0]                    csum_ff, csum_in;
   logic                          seen_ff, seen_in;
   logic [3:0]                    nibble;
   logic [7:0]                    xor_value;

   assign nibble    = rafc_pkg::hex_nibble(rx_byte);
   assign xor_value = rafc_pkg::xor_bytes(tag_ff);
   assign emit      = !capture_ff && (rx_byte == rafc_pkg::END_BYTE);

   always_comb begin
      result.tag_id            = tag_ff;
      result.computed_checksum = xor_value;
      result.received_checksum = csum_ff;
      result.checksum_ok       = (xor_value == csum_ff);
      result.frame_captured    = seen_ff;
   end

   always_comb begin
      capture_in = capture_ff;
      count_in   = count_ff;
      tag_in     = tag_ff;
      csum_in    = csum_ff;
      seen_in    = seen_ff;
      if (capture_ff) begin
         if (count_ff < CNT_W'(TAG_CHARS)) begin
            tag_in = {tag_ff[rafc_pkg::TAG_BITS-5:0], nibble};
         end else begin
            csum_in = {csum_ff[3:0], nibble};
         end
         if (count_ff == CNT_W'(TAG_CHARS + 1)) begin
            capture_in = 1'b0;
            count_in   = '0;
            seen_in    = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (rx_byte == rafc_pkg::START_BYTE) begin
         capture_in = 1'b1;
         count_in   = '0;
      end else if (rx_byte == rafc_pkg::END_BYTE) begin
         seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_ff <= 1'b0;
         count_ff   <= '0;
         tag_ff     <= '0;
         csum_ff    <= '0;
         seen_ff    <= 1'b0;
      end else if (step) begin
         capture_ff <= capture_in;
         count_ff   <= count_in;
         tag_ff     <= tag_in;
         csum_ff    <= csum_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rfid_ascii_frame_checker_unit.sv */
// Top level of the ASCII tag frame checker: input register, parser and result register.
// A request waits in the input register; any result goes to the result register as it leaves.
// Throughput: one request per cycle, limited only by the result register draining.
// Only the end byte seen while hunting produces a result; all other requests produce none.
// Reset is synchronous and active high; it clears the parser state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module rfid_ascii_frame_checker_unit #(
   parameter int unsigned TAG_CHARS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [39:0]      rsp_tag_id,
   output logic [7:0]       rsp_computed_checksum,
   output logic [7:0]       rsp_received_checksum,
   output logic             rsp_checksum_ok,
   output logic             rsp_frame_captured
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   rafc_pkg::result_type out_ff;
   rafc_pkg::result_type result;
   logic                 emit;
   logic                 advance;
   logic                 accept;

   // A byte leaves the input register unless it has a result and the output is full and stalled.
   assign advance   = in_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   rafc_parser #(
      .TAG_CHARS(TAG_CHARS)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .rx_byte(in_byte_ff),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_tag_id            = out_ff.tag_id;
   assign rsp_computed_checksum = out_ff.computed_checksum;
   assign rsp_received_checksum = out_ff.received_checksum;
   assign rsp_checksum_ok       = out_ff.checksum_ok;
   assign rsp_frame_captured    = out_ff.frame_captured;

   a_ok_matches : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_checksum_ok == (rsp_computed_checksum == rsp_received_checksum)))
      else $error("checksum_ok disagrees with the checksums");

   a_xor_matches : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_computed_checksum == rafc_pkg::xor_bytes(rsp_tag_id)))
      else $error("computed checksum is not the XOR of the tag bytes");

   a_reset_clears : assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("valid state survived reset");

   a_no_lost_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(advance && emit))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire
